@@ hw/rtl/bdc_pkg.sv @@
// Shared types and constants for the button debounce and click detector.
`timescale 1ns / 1ps

package bdc_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_INIT = 2'd2;

  // Bit positions in the event flag word and in clear_mask
  localparam int FLAG_PRESS        = 0;
  localparam int FLAG_RELEASE      = 1;
  localparam int FLAG_LONG_PRESS   = 2;
  localparam int FLAG_LONG_RELEASE = 3;
  localparam int FLAG_CLICK        = 4;
  localparam int FLAG_COUNT        = 5;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTEGRATOR_MAX    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRESS_THRESHOLD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_THRESHOLD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_TICKS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_MIN_PRESS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_LIMIT       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_IDLE_TICKS  = 3'd6;

  // Register reset values
  localparam logic [7:0]  RST_INTEGRATOR_MAX    = 8'd4;
  localparam logic [7:0]  RST_PRESS_THRESHOLD   = 8'd3;
  localparam logic [7:0]  RST_RELEASE_THRESHOLD = 8'd1;
  localparam logic [15:0] RST_LONG_TICKS        = 16'd100;
  localparam logic [15:0] RST_CLICK_MIN_PRESS   = 16'd2;
  localparam logic [7:0]  RST_CLICK_LIMIT       = 8'd8;
  localparam logic [15:0] RST_CLICK_IDLE_TICKS  = 16'd30;

  typedef struct packed {
    logic [7:0]  integrator_max;
    logic [7:0]  press_threshold;
    logic [7:0]  release_threshold;
    logic [15:0] long_ticks;
    logic [15:0] click_min_press;
    logic [7:0]  click_limit;
    logic [15:0] click_idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       raw_pressed;
    logic [4:0] clear_mask;
  } req_t;

  typedef struct packed {
    logic       is_pressed;
    logic       press_flag;
    logic       release_flag;
    logic       long_press_flag;
    logic       long_release_flag;
    logic       click_flag;
    logic [7:0] click_count;
  } res_t;

endpackage

@@ hw/rtl/bdc_cfg_regs.sv @@
// Configuration register file of the debounce and click detector.
`timescale 1ns / 1ps

module bdc_cfg_regs
  import bdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.integrator_max    <= RST_INTEGRATOR_MAX;
      cfg.press_threshold   <= RST_PRESS_THRESHOLD;
      cfg.release_threshold <= RST_RELEASE_THRESHOLD;
      cfg.long_ticks        <= RST_LONG_TICKS;
      cfg.click_min_press   <= RST_CLICK_MIN_PRESS;
      cfg.click_limit       <= RST_CLICK_LIMIT;
      cfg.click_idle_ticks  <= RST_CLICK_IDLE_TICKS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTEGRATOR_MAX:    cfg.integrator_max    <= cfg_data[7:0];
        CFG_PRESS_THRESHOLD:   cfg.press_threshold   <= cfg_data[7:0];
        CFG_RELEASE_THRESHOLD: cfg.release_threshold <= cfg_data[7:0];
        CFG_LONG_TICKS:        cfg.long_ticks        <= cfg_data;
        CFG_CLICK_MIN_PRESS:   cfg.click_min_press   <= cfg_data;
        CFG_CLICK_LIMIT:       cfg.click_limit       <= cfg_data[7:0];
        CFG_CLICK_IDLE_TICKS:  cfg.click_idle_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/bdc_core.sv @@
// Debounce state, timers, click count and sticky flags, updated once per item.
`timescale 1ns / 1ps

module bdc_core
  import bdc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic take,
  input  req_t req,
  output res_t res
);

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [7:0]            integrator, integrator_next;
  logic                  debounced, debounced_next;
  logic [TIMER_BITS-1:0] state_timer, state_timer_next;
  logic [7:0]            clicks, clicks_next;
  logic [FLAG_COUNT-1:0] event_flags, event_flags_next;

  logic [CMP_W-1:0] timer_ext, long_ext, min_ext, idle_ext;
  logic [CMP_W-1:0] timer_inc_ext;
  logic [FLAG_COUNT-1:0] shown;
  logic [7:0]            count;

  assign timer_ext = CMP_W'(state_timer);
  assign long_ext  = CMP_W'(cfg.long_ticks);
  assign min_ext   = CMP_W'(cfg.click_min_press);
  assign idle_ext  = CMP_W'(cfg.click_idle_ticks);

  // Work out next state and the result for the item in flight
  always_comb begin
    integrator_next  = integrator;
    debounced_next   = debounced;
    state_timer_next = state_timer;
    clicks_next      = clicks;
    event_flags_next = event_flags;
    timer_inc_ext    = timer_ext;
    shown            = event_flags;
    count            = clicks;
    case (req.req_type)
      REQ_TICK: begin
        // Step the integrator and switch state on a threshold hit
        if (req.raw_pressed) begin
          if (integrator < cfg.integrator_max) begin
            integrator_next = integrator + 8'd1;
            if (integrator_next == cfg.press_threshold && !debounced) begin
              debounced_next = 1'b1;
              event_flags_next[FLAG_PRESS] = 1'b1;
              state_timer_next = '0;
            end
          end
        end else if (integrator != 8'd0) begin
          integrator_next = integrator - 8'd1;
          if (integrator_next == cfg.release_threshold && debounced) begin
            if (timer_ext > min_ext && clicks < cfg.click_limit) begin
              clicks_next = clicks + 8'd1;
            end
            debounced_next = 1'b0;
            event_flags_next[FLAG_RELEASE] = 1'b1;
            state_timer_next = '0;
          end
        end
        // Advance the state timer and raise timed events
        if (state_timer_next != TIMER_MAX) begin
          state_timer_next = state_timer_next + TIMER_BITS'(1);
          timer_inc_ext    = CMP_W'(state_timer_next);
          if (timer_inc_ext == long_ext) begin
            if (debounced_next) begin
              event_flags_next[FLAG_LONG_PRESS] = 1'b1;
            end else begin
              event_flags_next[FLAG_LONG_RELEASE] = 1'b1;
            end
          end
          if (clicks_next != 8'd0 && !debounced_next && timer_inc_ext == idle_ext) begin
            event_flags_next[FLAG_CLICK] = 1'b1;
          end
        end
        shown = event_flags_next;
        count = clicks_next;
      end
      REQ_READ: begin
        // Report flags as they were, then clear the chosen ones
        if (req.clear_mask[FLAG_CLICK] && event_flags[FLAG_CLICK]) begin
          clicks_next = 8'd0;
        end
        event_flags_next = event_flags & ~req.clear_mask;
      end
      REQ_INIT: begin
        // Preset from the raw sample
        debounced_next   = req.raw_pressed;
        integrator_next  = req.raw_pressed ? cfg.integrator_max : 8'd0;
        event_flags_next = '0;
        state_timer_next = '0;
        clicks_next      = 8'd0;
        shown            = '0;
        count            = 8'd0;
      end
      default: ;
    endcase

    res.is_pressed        = debounced_next;
    res.press_flag        = shown[FLAG_PRESS];
    res.release_flag      = shown[FLAG_RELEASE];
    res.long_press_flag   = shown[FLAG_LONG_PRESS];
    res.long_release_flag = shown[FLAG_LONG_RELEASE];
    res.click_flag        = shown[FLAG_CLICK];
    res.click_count       = count;
  end

  // Hold state until an item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      integrator  <= 8'd0;
      debounced   <= 1'b0;
      state_timer <= '0;
      clicks      <= 8'd0;
      event_flags <= '0;
    end else if (take) begin
      integrator  <= integrator_next;
      debounced   <= debounced_next;
      state_timer <= state_timer_next;
      clicks      <= clicks_next;
      event_flags <= event_flags_next;
    end
  end

endmodule

@@ hw/rtl/bdc_out_reg.sv @@
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps

module bdc_out_reg
  import bdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t load_item,
  output logic can_load,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_item
);

  // Room for a new item when empty or when the held item leaves this cycle
  assign can_load = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_item <= load_item;
    end
  end

endmodule

@@ hw/rtl/button_debounce_click_detector.sv @@
// Top level of the button debounce, long-press and multi-click detector.
//
//   port group   direction  handshake            payload
//   in_*         in         in_valid/in_ready    req_t in_item
//   out_*        out        out_valid/out_ready  res_t out_item
//   cfg_*        in         cfg_we (no wait)     cfg_index, cfg_data
//
// One item per cycle unless the output stalls; each item's result, set by the single
// combinational pass of bdc_core, is loaded into the output register when it is taken.
// Synchronous active-high reset clears the state and flags and restores the configuration reset values.
// A stalled output holds in_ready low until the held item is taken.
`timescale 1ns / 1ps

module button_debounce_click_detector
  import bdc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  req_t                   in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output res_t                   out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  res_t res;
  logic take;

  assign take = in_valid && in_ready;

  bdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .req  (in_item),
    .res  (res)
  );

  bdc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_item (res),
    .can_load  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the button debounce, long-press and multi-click detector.
`timescale 1ns / 1ps

module testbench;
  import bdc_pkg::*;

  localparam int TIMER_BITS = 16;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // req_type code with no defined meaning
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Predicts every result of the detector and checks the results in order
  class click_scoreboard;
    cfg_t                  cfg;
    logic [7:0]            integ;
    logic                  debounced;
    logic [TIMER_BITS-1:0] timer;
    logic [7:0]            clicks;
    logic [FLAG_COUNT-1:0] flags;
    res_t                  expected_results[$];
    int unsigned           errors;

    function new();
      cfg.integrator_max    = RST_INTEGRATOR_MAX;
      cfg.press_threshold   = RST_PRESS_THRESHOLD;
      cfg.release_threshold = RST_RELEASE_THRESHOLD;
      cfg.long_ticks        = RST_LONG_TICKS;
      cfg.click_min_press   = RST_CLICK_MIN_PRESS;
      cfg.click_limit       = RST_CLICK_LIMIT;
      cfg.click_idle_ticks  = RST_CLICK_IDLE_TICKS;
      integ     = '0;
      debounced = 1'b0;
      timer     = '0;
      clicks    = '0;
      flags     = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INTEGRATOR_MAX:    cfg.integrator_max    = data[7:0];
        CFG_PRESS_THRESHOLD:   cfg.press_threshold   = data[7:0];
        CFG_RELEASE_THRESHOLD: cfg.release_threshold = data[7:0];
        CFG_LONG_TICKS:        cfg.long_ticks        = data;
        CFG_CLICK_MIN_PRESS:   cfg.click_min_press   = data;
        CFG_CLICK_LIMIT:       cfg.click_limit       = data[7:0];
        CFG_CLICK_IDLE_TICKS:  cfg.click_idle_ticks  = data;
        default: ;
      endcase
    endfunction

    // Advance the integrator, the debounced state and the state timer by one sample
    function void advance_tick(logic raw);
      if (raw) begin
        if (integ < cfg.integrator_max) begin
          integ = integ + 8'd1;
          if (integ == cfg.press_threshold && !debounced) begin
            debounced = 1'b1;
            flags[FLAG_PRESS] = 1'b1;
            timer = '0;
          end
        end
      end else if (integ != 8'd0) begin
        integ = integ - 8'd1;
        if (integ == cfg.release_threshold && debounced) begin
          if (timer > cfg.click_min_press && clicks < cfg.click_limit)
            clicks = clicks + 8'd1;
          debounced = 1'b0;
          flags[FLAG_RELEASE] = 1'b1;
          timer = '0;
        end
      end
      // hold the timer once it saturates
      if (timer != {TIMER_BITS{1'b1}}) begin
        timer = timer + TIMER_BITS'(1);
        if (timer == cfg.long_ticks) begin
          if (debounced) flags[FLAG_LONG_PRESS] = 1'b1;
          else flags[FLAG_LONG_RELEASE] = 1'b1;
        end
        if (clicks != 8'd0 && !debounced && timer == cfg.click_idle_ticks)
          flags[FLAG_CLICK] = 1'b1;
      end
    endfunction

    function void note_request(req_t r);
      logic [FLAG_COUNT-1:0] shown;
      logic [7:0]            count;
      res_t                  res;
      case (r.req_type)
        REQ_TICK: begin
          advance_tick(r.raw_pressed);
          shown = flags;
          count = clicks;
        end
        REQ_READ: begin
          shown = flags;
          count = clicks;
          // taking the click also zeroes the count
          if (r.clear_mask[FLAG_CLICK] && flags[FLAG_CLICK]) clicks = '0;
          flags = flags & ~r.clear_mask;
        end
        REQ_INIT: begin
          debounced = r.raw_pressed;
          integ     = r.raw_pressed ? cfg.integrator_max : 8'd0;
          flags     = '0;
          timer     = '0;
          clicks    = '0;
          shown     = flags;
          count     = clicks;
        end
        default: begin
          shown = flags;
          count = clicks;
        end
      endcase
      res.is_pressed        = debounced;
      res.press_flag        = shown[FLAG_PRESS];
      res.release_flag      = shown[FLAG_RELEASE];
      res.long_press_flag   = shown[FLAG_LONG_PRESS];
      res.long_release_flag = shown[FLAG_LONG_RELEASE];
      res.click_flag        = shown[FLAG_CLICK];
      res.click_count       = count;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("is_pressed", 8'(want.is_pressed), 8'(got.is_pressed));
      compare_field("press_flag", 8'(want.press_flag), 8'(got.press_flag));
      compare_field("release_flag", 8'(want.release_flag), 8'(got.release_flag));
      compare_field("long_press_flag", 8'(want.long_press_flag), 8'(got.long_press_flag));
      compare_field("long_release_flag", 8'(want.long_release_flag),
                    8'(got.long_release_flag));
      compare_field("click_flag", 8'(want.click_flag), 8'(got.click_flag));
      compare_field("click_count", want.click_count, got.click_count);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  res_t                   out_item;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bit                     no_gaps = 1'b0;
  int unsigned            cycle_count = 0;
  click_scoreboard        sb;

  button_debounce_click_detector #(.TIMER_BITS(TIMER_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if (in_valid && in_ready) sb.note_request(in_item);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive out_ready: random stalls, ready bursts and long hold-offs
  initial begin : receiver
    int unsigned holdoff;
    int unsigned burst;
    int unsigned r;
    holdoff = 0;
    burst   = 0;
    forever begin
      @(posedge clk);
      // back up the block once while the sender keeps offering items
      if (cycle_count == 3000) holdoff = 400;
      if (holdoff != 0) begin
        holdoff--;
        out_ready <= 1'b0;
      end else if (burst != 0) begin
        burst--;
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 127);
        if (r < 2) begin
          holdoff = $urandom_range(10, 60);
          out_ready <= 1'b0;
        end else if (r < 10) begin
          burst = $urandom_range(20, 200);
          out_ready <= 1'b1;
        end else begin
          out_ready <= ($urandom_range(0, 3) != 0);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offer one item, hold it until taken, then maybe idle
  task automatic send_req(logic [1:0] kind, logic raw, logic [4:0] mask);
    req_t        item;
    int unsigned gap;
    item.req_type    = kind;
    item.raw_pressed = raw;
    item.clear_mask  = mask;
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send a run of samples at one level, flipping about one in bounce when bounce is nonzero
  task automatic run_ticks(logic raw, int unsigned n, int unsigned bounce);
    logic sample;
    for (int unsigned i = 0; i < n; i++) begin
      sample = raw;
      if (bounce != 0 && $urandom_range(0, bounce - 1) == 0) sample = ~raw;
      send_req(REQ_TICK, sample, 5'($urandom_range(0, 31)));
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    // let the last accepted item reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write all seven registers in turn
  task automatic write_config(cfg_t c);
    logic [CFG_INDEX_W-1:0] order[7];
    logic [CFG_DATA_W-1:0]  data;
    order = '{CFG_INTEGRATOR_MAX, CFG_PRESS_THRESHOLD, CFG_RELEASE_THRESHOLD,
              CFG_LONG_TICKS, CFG_CLICK_MIN_PRESS, CFG_CLICK_LIMIT, CFG_CLICK_IDLE_TICKS};
    for (int i = 0; i < 7; i++) begin
      case (order[i])
        CFG_INTEGRATOR_MAX:    data = CFG_DATA_W'(c.integrator_max);
        CFG_PRESS_THRESHOLD:   data = CFG_DATA_W'(c.press_threshold);
        CFG_RELEASE_THRESHOLD: data = CFG_DATA_W'(c.release_threshold);
        CFG_LONG_TICKS:        data = c.long_ticks;
        CFG_CLICK_MIN_PRESS:   data = c.click_min_press;
        CFG_CLICK_LIMIT:       data = CFG_DATA_W'(c.click_limit);
        default:               data = c.click_idle_ticks;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= data;
      @(posedge clk);
      sb.set_reg(order[i], data);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly sample runs with bounce, mixed with reads, inits and odd requests
  task automatic random_phase(int unsigned n_items, cfg_t c);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    int unsigned span;
    sent = 0;
    span = 32'(c.long_ticks);
    if (c.click_idle_ticks > span) span = 32'(c.click_idle_ticks);
    if (c.integrator_max * 2 > span) span = c.integrator_max * 2;
    span = span + 8;
    if (span > 120) span = 120;
    while (sent < n_items) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = $urandom_range(1, span);
        run_ticks(1'($urandom_range(0, 1)), len, (r < 20) ? 4 : 0);
        sent += len;
      end else if (r < 80) begin
        send_req(REQ_READ, 1'($urandom_range(0, 1)),
                 (r < 72) ? 5'($urandom_range(0, 31)) : 5'h1f);
        sent++;
      end else if (r < 86) begin
        send_req(REQ_INIT, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        sent++;
      end else if (r < 90) begin
        send_req(REQ_UNUSED, 1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        sent++;
      end else begin
        send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 5'($urandom_range(0, 31)));
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    cfg_t c;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: short timings so each event shows up in a few items
    c = '{integrator_max: 8'd4, press_threshold: 8'd3, release_threshold: 8'd1,
          long_ticks: 16'd6, click_min_press: 16'd1, click_limit: 8'd2,
          click_idle_ticks: 16'd3};
    write_config(c);
    send_req(REQ_READ, 1'b0, 5'h00);
    send_req(REQ_UNUSED, 1'b1, 5'h1f);
    run_ticks(1'b1, 5, 0);
    send_req(REQ_READ, 1'b0, 5'h01);
    run_ticks(1'b0, 5, 0);
    // take the click, then read again and clear all flags
    send_req(REQ_READ, 1'b1, 5'h10);
    send_req(REQ_READ, 1'b0, 5'h1f);
    send_req(REQ_INIT, 1'b1, 5'h1f);
    run_ticks(1'b0, 1, 0);
    run_ticks(1'b1, 1, 0);
    send_req(REQ_READ, 1'b1, 5'h1f);
    send_req(REQ_INIT, 1'b0, 5'h00);
    run_ticks(1'b1, 1, 0);
    run_ticks(1'b0, 1, 0);
    send_req(REQ_READ, 1'b0, 5'h0a);
    drain();

    // Extremes: widest integrator limit and thresholds, press reached at the top
    c = '{integrator_max: 8'd255, press_threshold: 8'd255, release_threshold: 8'd254,
          long_ticks: 16'hffff, click_min_press: 16'hfffe, click_limit: 8'd255,
          click_idle_ticks: 16'hffff};
    write_config(c);
    send_req(REQ_INIT, 1'b0, 5'h00);
    no_gaps = 1'b1;
    run_ticks(1'b1, 260, 0);
    no_gaps = 1'b0;
    send_req(REQ_READ, 1'b0, 5'h1f);
    drain();

    // Lower the integrator limit under the current count; press threshold now out of reach
    c.integrator_max = 8'd2;
    write_config(c);
    run_ticks(1'b1, 3, 0);
    run_ticks(1'b0, 300, 0);
    run_ticks(1'b1, 10, 0);
    send_req(REQ_READ, 1'b1, 5'h1f);
    drain();

    // Smallest settings
    c = '{integrator_max: 8'd1, press_threshold: 8'd1, release_threshold: 8'd0,
          long_ticks: 16'd1, click_min_press: 16'd0, click_limit: 8'd1,
          click_idle_ticks: 16'd1};
    write_config(c);
    random_phase(150, c);
    drain();

    // Random small settings, a threshold now and then out of reach
    repeat (5) begin
      c.integrator_max    = 8'($urandom_range(1, 8));
      c.press_threshold   = ($urandom_range(0, 5) == 0) ? c.integrator_max + 8'd1
                                                         : 8'($urandom_range(1, c.integrator_max));
      c.release_threshold = 8'($urandom_range(0, c.integrator_max - 1));
      c.long_ticks        = 16'($urandom_range(1, 60));
      c.click_min_press   = 16'($urandom_range(0, 12));
      c.click_limit       = 8'($urandom_range(1, 6));
      c.click_idle_ticks  = 16'($urandom_range(1, 40));
      write_config(c);
      random_phase(170, c);
      drain();
    end

    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
